[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the dual via timer tick checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge, reset included
`define DVTT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dvtt assertion failed");

// checked outside reset only
`define DVTT_ASSERT_RUN(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dvtt assertion failed");

// antecedent this cycle, consequent on the next edge, outside reset
`define DVTT_ASSERT_NEXT(lbl, ante, cons) \
  `DVTT_ASSERT_RUN(lbl, (ante) |=> (cons))

`endif

[hdl/dvtt_pkg.sv]
// ----------------------------------------------------------------------------
// dvtt_pkg
// shared types and constants of the dual via timer tick block
// ----------------------------------------------------------------------------
package dvtt_pkg;

  localparam int unsigned HALF_W  = 7;
  localparam int unsigned CNT_W   = 18;
  localparam int unsigned ACC_W   = 17;
  localparam int unsigned LATCH_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IRQ_N   = 5;

  localparam logic [CFG_W-1:0]  FRAME_PERIOD_RST = 16'd20000;
  localparam logic [CNT_W-1:0]  CNT_MIN          = 18'h20000;
  localparam logic [ACC_W-1:0]  ACC_MAX          = 17'h1FFFF;

  typedef enum logic [2:0] {
    MODE_ADVANCE   = 3'd0,
    MODE_LD_SYS_T1 = 3'd1,
    MODE_LD_SYS_T2 = 3'd2,
    MODE_LD_USR_T1 = 3'd3,
    MODE_LD_USR_T2 = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    CFG_FRAME_PERIOD = 3'd0,
    CFG_SYS_T1_LATCH = 3'd1,
    CFG_SYS_T1_CONT  = 3'd2,
    CFG_SYS_T2_PULSE = 3'd3,
    CFG_USR_T1_LATCH = 3'd4,
    CFG_USR_T1_CONT  = 3'd5,
    CFG_USR_T2_PULSE = 3'd6
  } cfg_reg_t;

  // time step handed to every counter
  typedef struct packed {
    logic              adv;
    logic [HALF_W-1:0] half;
  } tick_t;

  // count minus half cycles, clamped at the most negative count
  function automatic logic [CNT_W-1:0] count_sub(input logic [CNT_W-1:0] c,
                                                 input logic [HALF_W-1:0] h);
    logic [CNT_W:0] d;
    d = {c[CNT_W-1], c} - {{(CNT_W+1-HALF_W){1'b0}}, h};
    count_sub = (d[CNT_W] != d[CNT_W-1]) ? CNT_MIN : d[CNT_W-1:0];
  endfunction

endpackage

[hdl/dual_via_timer_tick_core.sv]
// ----------------------------------------------------------------------------
// dual_via_timer_tick_core
// timers of a system and a user 6522 plus a frame-rate divider
// ----------------------------------------------------------------------------
// channel | dir | handshake                | payload
// in_     | in  | in_tvalid / in_tready    | tuser mode, tdata cycles + load value
// out_    | out | out_tvalid / out_tready  | tdata five interrupt flags
// cfg_    | in  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// one word per clock sustained while out_tready is high; each word is held in the
// input register, evaluated and registered in the result register
// counter updates are single-pass: add or subtract, compare, and reload where used
// rst_n is synchronous; config and counters take their reset values, no sweep
// out_tready low holds the result; the input register still takes one word
// cfg_ready is always high
// ----------------------------------------------------------------------------
module dual_via_timer_tick_core import dvtt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] cpu_cycles, [23:8] load_value
  input  logic [2:0]  in_tuser,   // [2:0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] frame_irq, [1] sys_t1_irq, [2] sys_t2_irq,
                                  // [3] usr_t1_irq, [4] usr_t2_irq, [7:5] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [CFG_W-1:0]   frame_period_r;
  logic [LATCH_W-1:0] sys_t1_latch_r, usr_t1_latch_r;
  logic               sys_t1_cont_r, sys_t2_pulse_r, usr_t1_cont_r, usr_t2_pulse_r;

  // input register
  logic               s1_v_r;
  mode_t              mode_r;
  logic [HALF_W-1:0]  half_r;
  logic [LATCH_W-1:0] load_value_r;

  // result register
  logic               out_v_r;
  logic [IRQ_N-1:0]   irq_r;

  logic               out_free, fire;
  tick_t              tick;
  logic               ld_sys_t1, ld_sys_t2, ld_usr_t1, ld_usr_t2;
  logic               frame_irq, sys_t1_irq, sys_t2_irq, usr_t1_irq, usr_t2_irq;
  logic [IRQ_N-1:0]   irq_nxt;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_v_r || out_tready;
  assign fire       = s1_v_r && out_free;
  assign in_tready  = !s1_v_r || out_free;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(8-IRQ_N){1'b0}}, irq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_period_r <= FRAME_PERIOD_RST;
      sys_t1_latch_r <= '0;
      usr_t1_latch_r <= '0;
      sys_t1_cont_r  <= 1'b0;
      sys_t2_pulse_r <= 1'b0;
      usr_t1_cont_r  <= 1'b0;
      usr_t2_pulse_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FRAME_PERIOD: frame_period_r <= cfg_data;
        CFG_SYS_T1_LATCH: sys_t1_latch_r <= cfg_data;
        CFG_SYS_T1_CONT:  sys_t1_cont_r  <= cfg_data[0];
        CFG_SYS_T2_PULSE: sys_t2_pulse_r <= cfg_data[0];
        CFG_USR_T1_LATCH: usr_t1_latch_r <= cfg_data;
        CFG_USR_T1_CONT:  usr_t1_cont_r  <= cfg_data[0];
        CFG_USR_T2_PULSE: usr_t2_pulse_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r       <= mode_t'(in_tuser);
      half_r       <= in_tdata[7:1];
      load_value_r <= in_tdata[23:8];
    end
  end

  // decode the held word
  always_comb begin
    tick.adv  = 1'b0;
    tick.half = half_r;
    ld_sys_t1 = 1'b0;
    ld_sys_t2 = 1'b0;
    ld_usr_t1 = 1'b0;
    ld_usr_t2 = 1'b0;
    case (mode_r)
      MODE_ADVANCE:   tick.adv  = fire;
      MODE_LD_SYS_T1: ld_sys_t1 = fire;
      MODE_LD_SYS_T2: ld_sys_t2 = fire;
      MODE_LD_USR_T1: ld_usr_t1 = fire;
      MODE_LD_USR_T2: ld_usr_t2 = fire;
      default: ;
    endcase
  end

  dvtt_frame_div u_frame (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick   (tick),
    .period (frame_period_r),
    .irq    (frame_irq)
  );

  dvtt_t1 u_sys_t1 (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .load       (ld_sys_t1),
    .load_value (load_value_r),
    .run        (sys_t1_cont_r),
    .latch      (sys_t1_latch_r),
    .irq        (sys_t1_irq)
  );

  dvtt_t2 u_sys_t2 (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .load       (ld_sys_t2),
    .load_value (load_value_r),
    .pulse      (sys_t2_pulse_r),
    .irq        (sys_t2_irq)
  );

  dvtt_t1 u_usr_t1 (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .load       (ld_usr_t1),
    .load_value (load_value_r),
    .run        (usr_t1_cont_r),
    .latch      (usr_t1_latch_r),
    .irq        (usr_t1_irq)
  );

  dvtt_t2 u_usr_t2 (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .load       (ld_usr_t2),
    .load_value (load_value_r),
    .pulse      (usr_t2_pulse_r),
    .irq        (usr_t2_irq)
  );

  // only advance words raise flags
  assign irq_nxt = (mode_r == MODE_ADVANCE) ?
                   {usr_t2_irq, usr_t1_irq, sys_t2_irq, sys_t1_irq, frame_irq} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      irq_r <= irq_nxt;
    end
  end

endmodule

[hdl/dvtt_frame_div.sv]
// ----------------------------------------------------------------------------
// dvtt_frame_div
// frame-rate divider: saturating sum of half cycles, flags one elapsed period
// ----------------------------------------------------------------------------
module dvtt_frame_div import dvtt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  tick_t            tick,
  input  logic [CFG_W-1:0] period,
  output logic             irq
);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [ACC_W:0]   sum;
  logic [ACC_W-1:0] sat;

  always_comb begin
    sum     = {1'b0, acc_r} + {{(ACC_W+1-HALF_W){1'b0}}, tick.half};
    sat     = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    irq     = (sat >= {{(ACC_W-CFG_W){1'b0}}, period});
    acc_nxt = irq ? (sat - {{(ACC_W-CFG_W){1'b0}}, period}) : sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (tick.adv) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

[hdl/dvtt_t1.sv]
// ----------------------------------------------------------------------------
// dvtt_t1
// timer 1: free-running countdown with latch reload, holds when not continuous
// ----------------------------------------------------------------------------
module dvtt_t1 import dvtt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  tick_t              tick,
  input  logic               load,
  input  logic [LATCH_W-1:0] load_value,
  input  logic               run,
  input  logic [LATCH_W-1:0] latch,
  output logic               irq
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] sub;

  always_comb begin
    sub     = count_sub(cnt_r, tick.half);
    irq     = run && (sub[CNT_W-1] || (sub == '0));
    cnt_nxt = irq ? (sub + {{(CNT_W-LATCH_W){1'b0}}, latch}) : sub;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= {{(CNT_W-LATCH_W){1'b0}}, load_value};
    end else if (tick.adv && run) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hdl/dvtt_t2.sv]
// ----------------------------------------------------------------------------
// dvtt_t2
// timer 2: one-shot countdown, fires once per load, holds in pulse mode
// ----------------------------------------------------------------------------
module dvtt_t2 import dvtt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  tick_t              tick,
  input  logic               load,
  input  logic [LATCH_W-1:0] load_value,
  input  logic               pulse,
  output logic               irq
);

  logic [CNT_W-1:0] cnt_r;
  logic             armed_r;
  logic [CNT_W-1:0] sub;

  always_comb begin
    sub = count_sub(cnt_r, tick.half);
    irq = !pulse && armed_r && (sub[CNT_W-1] || (sub == '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      armed_r <= 1'b0;
    end else if (load) begin
      cnt_r   <= {{(CNT_W-LATCH_W){1'b0}}, load_value};
      armed_r <= 1'b1;
    end else if (tick.adv && !pulse) begin
      // disarmed timer keeps counting down without firing
      cnt_r <= sub;
      if (irq) begin
        armed_r <= 1'b0;
      end
    end
  end

endmodule

[hdl/dvtt_checker.sv]
// ----------------------------------------------------------------------------
// dvtt_checker
// port-level checks on the dual via timer tick core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dvtt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // nothing comes out right after reset
  `DVTT_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_tvalid)

  // spare result bits stay clear
  `DVTT_ASSERT_ALWAYS(a_pad_zero, out_tdata[7:5] == 3'b000)

  // a draining output side never blocks the input
  `DVTT_ASSERT_ALWAYS(a_no_bubble, out_tready |-> in_tready)

  // a stalled result holds
  `DVTT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind dual_via_timer_tick_core dvtt_checker u_dvtt_checker (.*);

[sim/tb_dual_via_timer_tick_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_via_timer_tick_core
// self-checking bench for the dual 6522 timer and frame divider core
// ----------------------------------------------------------------------------
// a directed table covers reset state, ignored modes, held timers, disarmed
// timer 2, zero and extreme frame periods and ignored register indexes; a soak
// drives every counter into saturation; random phases follow under fixed and
// random register settings with random gaps on the input and stalls on the output.
// each result word is checked against its fixed entry or a predictor in the bench
// ----------------------------------------------------------------------------
module tb_dual_via_timer_tick_core;
  import dvtt_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PLAN_LEN      = 31;
  localparam int REG_COUNT     = 7;
  localparam int SOAK_WORDS    = 1040;
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_WORDS   = 25;
  localparam int CNT_FLOOR     = -131072;
  localparam logic [17:0] ACC_CEIL = 18'd131071;

  localparam logic [2:0] MODE_UNUSED5   = 3'd5;
  localparam logic [2:0] MODE_UNUSED6   = 3'd6;
  localparam logic [2:0] MODE_UNUSED7   = 3'd7;
  localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

  // frame sits in bit 0, matching out_tdata
  typedef struct packed {
    logic usr_t2;
    logic usr_t1;
    logic sys_t2;
    logic sys_t1;
    logic frame;
  } irq_word_t;

  localparam irq_word_t NO_IRQ = '0;

  typedef struct packed {
    logic       is_reg;   // register write instead of a word
    logic [2:0] code;     // mode, or register index
    logic [7:0] cycles;
    logic [15:0] value;   // load value, or register data
    logic       fixed;    // expectation typed in below
    irq_word_t  want;
  } plan_row_t;

  localparam logic WORD = 1'b0;
  localparam logic REG  = 1'b1;
  localparam logic FIX  = 1'b1;
  localparam logic PRED = 1'b0;

  plan_row_t plan [PLAN_LEN] = '{
    '{WORD, MODE_ADVANCE,     8'd255, 16'h0000, FIX,  NO_IRQ},
    '{WORD, MODE_UNUSED5,     8'd255, 16'hFFFF, FIX,  NO_IRQ},
    '{WORD, MODE_UNUSED6,     8'd0,   16'h0000, FIX,  NO_IRQ},
    '{WORD, MODE_UNUSED7,     8'd170, 16'hAAAA, FIX,  NO_IRQ},
    '{WORD, MODE_LD_SYS_T2,   8'd0,   16'h0000, FIX,  NO_IRQ},
    '{WORD, MODE_ADVANCE,     8'd0,   16'h0000, PRED, NO_IRQ},
    '{WORD, MODE_LD_USR_T2,   8'd85,  16'hFFFF, FIX,  NO_IRQ},
    '{WORD, MODE_LD_SYS_T1,   8'd0,   16'hFFFF, FIX,  NO_IRQ},
    '{WORD, MODE_LD_USR_T1,   8'd0,   16'h0001, FIX,  NO_IRQ},
    '{WORD, MODE_ADVANCE,     8'd3,   16'h0000, PRED, NO_IRQ},
    '{REG,  CFG_FRAME_PERIOD, 8'd0,   16'h0000, PRED, NO_IRQ},
    '{REG,  CFG_SYS_T1_CONT,  8'd0,   16'h0001, PRED, NO_IRQ},
    '{REG,  CFG_SYS_T1_LATCH, 8'd0,   16'hFFFF, PRED, NO_IRQ},
    '{REG,  CFG_USR_T1_CONT,  8'd0,   16'h0001, PRED, NO_IRQ},
    '{REG,  CFG_USR_T1_LATCH, 8'd0,   16'h0000, PRED, NO_IRQ},
    '{REG,  CFG_SYS_T2_PULSE, 8'd0,   16'h0001, PRED, NO_IRQ},
    '{REG,  CFG_USR_T2_PULSE, 8'd0,   16'h0000, PRED, NO_IRQ},
    '{REG,  CFG_UNUSED_IDX,   8'd0,   16'hFFFF, PRED, NO_IRQ},
    '{WORD, MODE_ADVANCE,     8'd255, 16'h0000, PRED, NO_IRQ},
    '{WORD, MODE_ADVANCE,     8'd2,   16'h0000, PRED, NO_IRQ},
    '{WORD, MODE_LD_SYS_T2,   8'd0,   16'h0005, FIX,  NO_IRQ},
    '{WORD, MODE_ADVANCE,     8'd255, 16'h0000, PRED, NO_IRQ},
    '{REG,  CFG_FRAME_PERIOD, 8'd0,   16'hFFFF, PRED, NO_IRQ},
    '{REG,  CFG_SYS_T2_PULSE, 8'd0,   16'h0000, PRED, NO_IRQ},
    '{REG,  CFG_USR_T2_PULSE, 8'd0,   16'h0001, PRED, NO_IRQ},
    '{WORD, MODE_ADVANCE,     8'd255, 16'h0000, PRED, NO_IRQ},
    '{WORD, MODE_LD_USR_T2,   8'd0,   16'h0000, FIX,  NO_IRQ},
    '{WORD, MODE_ADVANCE,     8'd254, 16'h0000, PRED, NO_IRQ},
    '{REG,  CFG_FRAME_PERIOD, 8'd0,   16'h0001, PRED, NO_IRQ},
    '{WORD, MODE_ADVANCE,     8'd255, 16'h0000, PRED, NO_IRQ},
    '{WORD, MODE_ADVANCE,     8'd1,   16'h0000, PRED, NO_IRQ}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [7:0] cpu_cycles, [23:8] load_value
  logic [2:0]  in_tuser   = '0;   // [2:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [7:0]  out_tdata;         // [0] frame, [1] sys t1, [2] sys t2, [3] usr t1,
                                  // [4] usr t2, [7:5] zero
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  // predictor copy of registers and state
  logic [15:0]        frame_period_q = FRAME_PERIOD_RST;
  logic [15:0]        sys_t1_reload  = '0;
  logic [15:0]        usr_t1_reload  = '0;
  logic               sys_t1_free    = 1'b0;
  logic               sys_t2_pulse   = 1'b0;
  logic               usr_t1_free    = 1'b0;
  logic               usr_t2_pulse   = 1'b0;
  logic [16:0]        frame_acc      = '0;
  logic signed [17:0] sys_t1_cnt     = '0;
  logic signed [17:0] sys_t2_cnt     = '0;
  logic signed [17:0] usr_t1_cnt     = '0;
  logic signed [17:0] usr_t2_cnt     = '0;
  logic               sys_t2_armed   = 1'b0;
  logic               usr_t2_armed   = 1'b0;

  irq_word_t pending_irqs[$];
  logic      calm = 1'b0;
  int        cycle_count = 0;
  int        mismatches = 0;
  int        results_seen = 0;
  int        advance_words = 0;
  int        load_words = 0;
  int        ignored_words = 0;
  int        reg_writes = 0;
  int        frame_irqs = 0;
  int        timer_irqs = 0;

  dual_via_timer_tick_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_irqs.size());
      $display("dual_via_timer_tick_core verification failed");
      $finish;
    end
  end

  function automatic logic signed [17:0] sub_clamped(input logic signed [17:0] c,
                                                     input logic [6:0] h);
    int d;
    d = int'(c) - int'(h);
    return (d < CNT_FLOOR) ? 18'(CNT_FLOOR) : 18'(d);
  endfunction

  function automatic logic step_t1(inout logic signed [17:0] cnt, input logic run,
                                   input logic [15:0] reload, input logic [6:0] h);
    if (!run) return 1'b0;
    cnt = sub_clamped(cnt, h);
    if (cnt <= 0) begin
      cnt = cnt + $signed({2'b00, reload});
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // timer 2 keeps counting while disarmed but only fires when armed
  function automatic logic step_t2(inout logic signed [17:0] cnt, inout logic armed,
                                   input logic pulse, input logic [6:0] h);
    if (pulse) return 1'b0;
    cnt = sub_clamped(cnt, h);
    if (armed && cnt <= 0) begin
      armed = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic irq_word_t predict_irqs(input logic [2:0] m, input logic [7:0] cyc,
                                             input logic [15:0] lv);
    irq_word_t  flags;
    logic [6:0] h;
    logic [17:0] acc;
    flags = NO_IRQ;
    h = cyc[7:1];
    case (m)
      MODE_ADVANCE: begin
        acc = {1'b0, frame_acc} + 18'(h);
        if (acc > ACC_CEIL) acc = ACC_CEIL;
        if (acc >= 18'(frame_period_q)) begin
          acc = acc - 18'(frame_period_q);
          flags.frame = 1'b1;
        end
        frame_acc = acc[16:0];
        flags.sys_t1 = step_t1(sys_t1_cnt, sys_t1_free, sys_t1_reload, h);
        flags.sys_t2 = step_t2(sys_t2_cnt, sys_t2_armed, sys_t2_pulse, h);
        flags.usr_t1 = step_t1(usr_t1_cnt, usr_t1_free, usr_t1_reload, h);
        flags.usr_t2 = step_t2(usr_t2_cnt, usr_t2_armed, usr_t2_pulse, h);
      end
      MODE_LD_SYS_T1: sys_t1_cnt = $signed({2'b00, lv});
      MODE_LD_SYS_T2: begin
        sys_t2_cnt   = $signed({2'b00, lv});
        sys_t2_armed = 1'b1;
      end
      MODE_LD_USR_T1: usr_t1_cnt = $signed({2'b00, lv});
      MODE_LD_USR_T2: begin
        usr_t2_cnt   = $signed({2'b00, lv});
        usr_t2_armed = 1'b1;
      end
      default: ;
    endcase
    return flags;
  endfunction

  function automatic logic [15:0] pick_count();
    return $urandom_range(1) ? 16'($urandom_range(800)) : 16'($urandom);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic send_word(input logic [2:0] m, input logic [7:0] cyc,
                           input logic [15:0] lv, input logic fixed,
                           input irq_word_t want);
    irq_word_t predicted;
    while (!calm && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 24'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= {lv, cyc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = predict_irqs(m, cyc, lv);
    pending_irqs.push_back(fixed ? want : predicted);
    if (m == MODE_ADVANCE) advance_words++;
    else if (m <= MODE_LD_USR_T2) load_words++;
    else ignored_words++;
  endtask

  // registers change only with nothing in flight
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_irqs.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_FRAME_PERIOD: frame_period_q = val;
      CFG_SYS_T1_LATCH: sys_t1_reload  = val;
      CFG_SYS_T1_CONT:  sys_t1_free    = val[0];
      CFG_SYS_T2_PULSE: sys_t2_pulse   = val[0];
      CFG_USR_T1_LATCH: usr_t1_reload  = val;
      CFG_USR_T1_CONT:  usr_t1_free    = val[0];
      CFG_USR_T2_PULSE: usr_t2_pulse   = val[0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_result(input logic [7:0] word);
    irq_word_t got;
    irq_word_t want;
    got = irq_word_t'(word[4:0]);
    results_seen++;
    frame_irqs += got.frame;
    timer_irqs += $countones(word[4:1]);
    if (pending_irqs.size() == 0) begin
      flag_mismatch($sformatf("result word %b with nothing expected", word));
    end else begin
      want = pending_irqs.pop_front();
      if (got !== want || word[7:5] !== 3'b000)
        flag_mismatch($sformatf({"exp/got frame %b/%b sys_t1 %b/%b sys_t2 %b/%b ",
                                 "usr_t1 %b/%b usr_t2 %b/%b pad 000/%b"},
                                want.frame, got.frame, want.sys_t1, got.sys_t1,
                                want.sys_t2, got.sys_t2, want.usr_t1, got.usr_t1,
                                want.usr_t2, got.usr_t2, word[7:5]));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result(out_tdata);
    out_tready <= !rst_n || calm || ($urandom_range(99) >= 7);
  end

  initial begin
    logic [15:0] regval [REG_COUNT];
    logic [2:0]  m;
    logic [7:0]  cyc;
    logic [15:0] lv;
    int          r;
    int          n;
    int          ph;
    int          k;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < PLAN_LEN; k++) begin
      if (plan[k].is_reg) begin
        settle();
        write_register(plan[k].code, plan[k].value);
      end else begin
        send_word(plan[k].code, plan[k].cycles, plan[k].value, plan[k].fixed, plan[k].want);
      end
    end

    // zero period with zero reloads: accumulator and every count run into saturation
    settle();
    regval[CFG_FRAME_PERIOD] = 16'h0000;
    regval[CFG_SYS_T1_LATCH] = 16'h0000;
    regval[CFG_SYS_T1_CONT]  = 16'h0001;
    regval[CFG_SYS_T2_PULSE] = 16'h0000;
    regval[CFG_USR_T1_LATCH] = 16'h0000;
    regval[CFG_USR_T1_CONT]  = 16'h0001;
    regval[CFG_USR_T2_PULSE] = 16'h0000;
    for (k = 0; k < REG_COUNT; k++) write_register(3'(k), regval[k]);
    // every count starts from zero so the soak reaches the floor
    send_word(MODE_LD_SYS_T1, 8'd0, 16'h0000, FIX, NO_IRQ);
    send_word(MODE_LD_SYS_T2, 8'd0, 16'h0000, FIX, NO_IRQ);
    send_word(MODE_LD_USR_T1, 8'd0, 16'h0000, FIX, NO_IRQ);
    send_word(MODE_LD_USR_T2, 8'd0, 16'h0000, FIX, NO_IRQ);
    for (k = 0; k < SOAK_WORDS; k++) begin
      // long stretch with no gaps and no stalls
      calm = (k >= 200 && k < 600);
      send_word(MODE_ADVANCE, 8'd255, 16'h0000, PRED, NO_IRQ);
    end
    calm = 1'b0;
    settle();
    write_register(CFG_FRAME_PERIOD, 16'hFFFF);
    write_register(CFG_SYS_T1_LATCH, 16'hFFFF);
    for (k = 0; k < 12; k++) send_word(MODE_ADVANCE, 8'($urandom), 16'h0000, PRED, NO_IRQ);

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          regval[CFG_FRAME_PERIOD] = 16'h0001;
          regval[CFG_SYS_T1_LATCH] = 16'h0000;
          regval[CFG_SYS_T1_CONT]  = 16'h0001;
          regval[CFG_SYS_T2_PULSE] = 16'h0000;
          regval[CFG_USR_T1_LATCH] = 16'h0000;
          regval[CFG_USR_T1_CONT]  = 16'h0001;
          regval[CFG_USR_T2_PULSE] = 16'h0000;
        end
        1: begin
          regval[CFG_FRAME_PERIOD] = 16'hFFFF;
          regval[CFG_SYS_T1_LATCH] = 16'hFFFF;
          regval[CFG_SYS_T1_CONT]  = 16'h0001;
          regval[CFG_SYS_T2_PULSE] = 16'h0000;
          regval[CFG_USR_T1_LATCH] = 16'hFFFF;
          regval[CFG_USR_T1_CONT]  = 16'h0001;
          regval[CFG_USR_T2_PULSE] = 16'h0000;
        end
        default: begin
          case ($urandom_range(3))
            0: regval[CFG_FRAME_PERIOD] = 16'($urandom_range(400, 1));
            1: regval[CFG_FRAME_PERIOD] = 16'($urandom_range(5000, 400));
            2: regval[CFG_FRAME_PERIOD] = 16'($urandom);
            default: regval[CFG_FRAME_PERIOD] = FRAME_PERIOD_RST;
          endcase
          regval[CFG_SYS_T1_LATCH] = pick_count();
          regval[CFG_USR_T1_LATCH] = pick_count();
          // upper data bits are junk for the one-bit registers
          regval[CFG_SYS_T1_CONT]  = {15'($urandom), 1'($urandom_range(3) != 0)};
          regval[CFG_SYS_T2_PULSE] = {15'($urandom), 1'($urandom_range(3) == 0)};
          regval[CFG_USR_T1_CONT]  = {15'($urandom), 1'($urandom_range(3) != 0)};
          regval[CFG_USR_T2_PULSE] = {15'($urandom), 1'($urandom_range(3) == 0)};
          if (ph == 2) begin
            regval[CFG_SYS_T1_CONT][0]  = 1'b0;
            regval[CFG_USR_T1_CONT][0]  = 1'b0;
            regval[CFG_SYS_T2_PULSE][0] = 1'b1;
            regval[CFG_USR_T2_PULSE][0] = 1'b1;
          end
        end
      endcase
      for (k = 0; k < REG_COUNT; k++) write_register(3'(k), regval[k]);

      n = 0;
      while (n < PHASE_WORDS) begin
        r = $urandom_range(99);
        cyc = 8'($urandom);
        if (r < 60) begin
          m  = MODE_ADVANCE;
          lv = 16'($urandom);
        end else if (r < 93) begin
          m  = 3'($urandom_range(MODE_LD_USR_T2, MODE_LD_SYS_T1));
          lv = pick_count();
        end else begin
          m  = 3'($urandom_range(MODE_UNUSED7, MODE_UNUSED5));
          lv = 16'($urandom);
        end
        send_word(m, cyc, lv, PRED, NO_IRQ);
        if (m <= MODE_LD_USR_T2) begin
          n++;
        end
      end
    end
    calm = 1'b0;

    settle();
    repeat (10) @(posedge clk);
    if (pending_irqs.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_irqs.size()));
    $display("words in: %0d advance, %0d load, %0d ignored; %0d register writes",
             advance_words, load_words, ignored_words, reg_writes);
    $display("results checked: %0d (%0d frame irqs, %0d timer irqs), %0d mismatches",
             results_seen, frame_irqs, timer_irqs, mismatches);
    if (mismatches == 0) begin
      $display("dual_via_timer_tick_core verification clean");
    end else begin
      $display("dual_via_timer_tick_core verification failed");
    end
    $finish;
  end

endmodule

[dual_via_timer_tick_core.f]
+incdir+hdl
hdl/dvtt_pkg.sv
hdl/dvtt_frame_div.sv
hdl/dvtt_t1.sv
hdl/dvtt_t2.sv
hdl/dual_via_timer_tick_core.sv
hdl/dvtt_checker.sv
sim/tb_dual_via_timer_tick_core.sv
